// File: hw/rtl/sds_pkg.sv
// Shared types and constants for the string delimiter splitter.
// No dependencies; every other file of the block imports this package.
package sds_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 4;
    localparam int CNT_OUT_W   = 16;
    localparam int LIMIT_W     = 16;
    localparam int DELIM_CFG_W = 64;
    localparam int CFG_IDX_W   = 2;

    localparam int DEF_MAX_DELIM_BYTES = 8;
    localparam int DEF_COUNT_BITS      = 16;

    localparam logic [DELIM_CFG_W-1:0] RST_DELIM      = 64'd44;
    localparam logic [LEN_W-1:0]       RST_DELIM_LEN  = 4'd1;
    localparam logic [LIMIT_W-1:0]     RST_MAX_ELEMS  = 16'hFFFF;
    localparam logic [LIMIT_W-1:0]     RST_MAX_LEN    = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELIM_BYTES = 2'd0,
        CFG_DELIM_LEN   = 2'd1,
        CFG_MAX_ELEMS   = 2'd2,
        CFG_MAX_LEN     = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_END_ELEM = 2'd1,
        KIND_END_STR  = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DROP,
        ST_FLUSH,
        ST_CHAR,
        ST_CHAR_CLOSE,
        ST_END_CLOSE,
        ST_END_MARK,
        ST_FINISH
    } t_state;

    // window control from the sequencer
    typedef struct packed {
        logic load;
        logic shift;
        logic clear;
    } t_win_ctl;

    // window status back to the sequencer
    typedef struct packed {
        logic front_valid;
        logic full_len;
        logic beyond_len;
        logic match;
    } t_win_stat;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] count;
        t_kind                kind;
        logic [BYTE_W-1:0]    data;
    } t_result;

endpackage

// File: hw/rtl/sds_cell.sv
// One lookahead cell: holds a byte, shifts toward the front, compares
// against its delimiter byte. Depends on sds_pkg.
module sds_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sds_pkg::t_win_ctl i_ctl,
    input  logic [7:0]        i_byte,
    input  logic [7:0]        i_delim,
    input  logic              i_prev_valid,
    input  logic              i_next_valid,
    input  logic [7:0]        i_next_data,
    output logic              o_valid,
    output logic [7:0]        o_data,
    output logic              o_match
);
    import sds_pkg::*;

    logic       r_valid;
    logic [7:0] r_data;
    logic       n_valid;
    logic [7:0] n_data;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctl.shift) begin
            n_valid = i_next_valid;
            n_data  = i_next_data;
        end else if (i_ctl.load && !r_valid && i_prev_valid) begin
            n_valid = 1'b1;
            n_data  = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_match = (r_data == i_delim);

endmodule

// File: hw/rtl/sds_window.sv
// Lookahead window: a row of sds_cell stages with the delimiter match
// and fill flags gathered for the sequencer. Depends on sds_pkg, sds_cell.
module sds_window #(
    parameter int MAX_DELIM_BYTES = sds_pkg::DEF_MAX_DELIM_BYTES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sds_pkg::t_win_ctl            i_ctl,
    input  logic [7:0]                   i_byte,
    input  logic [MAX_DELIM_BYTES*8-1:0] i_delim,
    input  logic [sds_pkg::LEN_W-1:0]    i_len,
    output sds_pkg::t_win_stat           o_stat,
    output logic [7:0]                   o_front
);
    import sds_pkg::*;

    logic [MAX_DELIM_BYTES-1:0] w_valid;
    logic [MAX_DELIM_BYTES-1:0] w_match;
    logic [MAX_DELIM_BYTES-1:0] w_in_len;
    logic [MAX_DELIM_BYTES-1:0] w_last;
    logic [7:0]                 w_data [MAX_DELIM_BYTES];

    for (genvar j = 0; j < MAX_DELIM_BYTES; j++) begin : g_cell
        logic       w_prev_valid;
        logic       w_next_valid;
        logic [7:0] w_next_data;

        if (j == 0) begin : g_head
            assign w_prev_valid = 1'b1;
        end else begin : g_mid
            assign w_prev_valid = w_valid[j-1];
        end

        if (j == MAX_DELIM_BYTES - 1) begin : g_tail
            assign w_next_valid = 1'b0;
            assign w_next_data  = 8'd0;
        end else begin : g_body
            assign w_next_valid = w_valid[j+1];
            assign w_next_data  = w_data[j+1];
        end

        assign w_in_len[j] = (LEN_W'(j) < i_len);
        assign w_last[j]   = (LEN_W'(j + 1) == i_len);

        sds_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_byte       (i_byte),
            .i_delim      (i_delim[j*8 +: 8]),
            .i_prev_valid (w_prev_valid),
            .i_next_valid (w_next_valid),
            .i_next_data  (w_next_data),
            .o_valid      (w_valid[j]),
            .o_data       (w_data[j]),
            .o_match      (w_match[j])
        );
    end

    always_comb begin
        o_stat.front_valid = w_valid[0];
        o_stat.full_len    = 1'b0;
        o_stat.beyond_len  = 1'b0;
        o_stat.match       = 1'b1;
        for (int j = 0; j < MAX_DELIM_BYTES; j++) begin
            o_stat.full_len   = o_stat.full_len | (w_valid[j] & w_last[j]);
            o_stat.beyond_len = o_stat.beyond_len | (w_valid[j] & ~w_in_len[j]);
            o_stat.match      = o_stat.match & (~w_in_len[j] | w_match[j]);
        end
    end

    assign o_front = w_data[0];

endmodule

// File: hw/rtl/string_delimiter_splitter.sv
// String delimiter splitter, top level: config registers, sequencer, output register.
// Depends on sds_pkg and sds_window.
// Bytes enter one at a time; a zero byte ends the string and gives an end-of-string
// word with the element count. A byte is accepted only while the sequencer is idle.
// With a delimiter set, the byte is loaded into the window, and each scan step then
// passes the front byte on or skips it, or removes a matched delimiter, until the
// window no longer holds a full delimiter length and the sequencer returns to idle.
// A match removes the whole delimiter at once, except after the delimiter length has
// been lowered mid-string, when ST_DROP shifts it out one byte at a time. A zero
// byte, or any byte while the delimiter length is zero, first flushes the held window
// bytes and then passes through the closing states. A result word waits in a holding
// register until the next word or the end of the run is known, so a step that passes
// a word on stalls while the output register is full and not taken by the sink.
module string_delimiter_splitter #(
    parameter int MAX_DELIM_BYTES = sds_pkg::DEF_MAX_DELIM_BYTES,
    parameter int COUNT_BITS      = sds_pkg::DEF_COUNT_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [7:0]                      i_s_axis_tdata,   // in_byte
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [23:0]                     o_m_axis_tdata,   // out_byte, element_count
    output logic [1:0]                      o_m_axis_tuser,   // out_kind
    output logic                            o_m_axis_tlast,   // last_of_run
    input  logic                            i_cfg_we,
    input  logic [sds_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sds_pkg::DELIM_CFG_W-1:0] i_cfg_wdata
);
    import sds_pkg::*;

    localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

    // config
    logic [DELIM_CFG_W-1:0] r_delim;
    logic [LEN_W-1:0]       r_dlen;
    logic [LIMIT_W-1:0]     r_max_elems;
    logic [LIMIT_W-1:0]     r_max_len;

    // control state
    t_state                 r_state, n_state;
    logic [COUNT_BITS-1:0]  r_cur, n_cur;
    logic [COUNT_BITS-1:0]  r_done, n_done;
    logic                   r_skip, n_skip;
    logic                   r_limit, n_limit;
    logic [LEN_W-1:0]       r_drop, n_drop;
    logic                   r_zero, n_zero;
    logic [7:0]             r_byte, n_byte;
    logic                   r_pend_v;
    t_result                r_pend;
    logic                   r_out_v;
    t_result                r_out;
    logic                   r_out_last;

    t_win_ctl               w_ctl;
    t_win_stat              w_stat;
    logic [7:0]             w_front;
    logic [LEN_W-1:0]       w_len;
    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_go;
    logic                   w_lim_now;
    logic                   w_trunc;
    logic [COUNT_BITS-1:0]  w_done_inc;
    logic [COUNT_BITS-1:0]  w_cur_inc;
    logic                   w_em;
    t_result                w_res;
    logic                   w_fin;

    assign w_len      = (r_dlen > LEN_W'(MAX_DELIM_BYTES)) ? LEN_W'(MAX_DELIM_BYTES) : r_dlen;
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_v || i_m_axis_tready;
    assign w_go       = !r_pend_v || w_out_free;

    assign w_lim_now  = r_limit || (CMP_W'(r_done) >= CMP_W'(r_max_elems));
    assign w_trunc    = (r_max_len != '0) && (CMP_W'(r_cur) >= CMP_W'(r_max_len - 1'b1));
    assign w_done_inc = (r_done == '1) ? r_done : r_done + 1'b1;
    assign w_cur_inc  = (r_cur == '1) ? r_cur : r_cur + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim     <= RST_DELIM;
            r_dlen      <= RST_DELIM_LEN;
            r_max_elems <= RST_MAX_ELEMS;
            r_max_len   <= RST_MAX_LEN;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DELIM_BYTES: r_delim     <= i_cfg_wdata;
                CFG_DELIM_LEN:   r_dlen      <= i_cfg_wdata[LEN_W-1:0];
                CFG_MAX_ELEMS:   r_max_elems <= i_cfg_wdata[LIMIT_W-1:0];
                CFG_MAX_LEN:     r_max_len   <= i_cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    sds_window #(
        .MAX_DELIM_BYTES (MAX_DELIM_BYTES)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_byte  (i_s_axis_tdata),
        .i_delim (r_delim[MAX_DELIM_BYTES*8-1:0]),
        .i_len   (w_len),
        .o_stat  (w_stat),
        .o_front (w_front)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_s_axis_tdata == 8'd0 || w_len == '0) ? ST_FLUSH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_go) begin
                    if (!w_stat.full_len) begin
                        n_state = ST_IDLE;
                    end else if (w_stat.match && w_stat.beyond_len && w_len > LEN_W'(1)) begin
                        n_state = ST_DROP;
                    end
                end
            end
            ST_DROP: begin
                if (r_drop == LEN_W'(1)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_FLUSH: begin
                if (w_go && !w_stat.front_valid) begin
                    n_state = r_zero ? ST_END_CLOSE : ST_CHAR;
                end
            end
            ST_CHAR: begin
                if (w_go) begin
                    n_state = w_lim_now ? ST_FINISH : ST_CHAR_CLOSE;
                end
            end
            ST_CHAR_CLOSE: begin
                if (w_go) begin
                    n_state = ST_FINISH;
                end
            end
            ST_END_CLOSE: begin
                if (w_go) begin
                    n_state = ST_END_MARK;
                end
            end
            ST_END_MARK: begin
                if (w_go) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // actions
    always_comb begin
        n_cur     = r_cur;
        n_done    = r_done;
        n_skip    = r_skip;
        n_limit   = r_limit;
        n_drop    = r_drop;
        n_zero    = r_zero;
        n_byte    = r_byte;
        w_ctl     = '0;
        w_em      = 1'b0;
        w_fin     = 1'b0;
        w_res     = '{count: CNT_OUT_W'(CMP_W'(r_done)), kind: KIND_DATA, data: 8'd0};
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_byte     = i_s_axis_tdata;
                    n_zero     = (i_s_axis_tdata == 8'd0);
                    w_ctl.load = (i_s_axis_tdata != 8'd0) && (w_len != '0);
                end
            end
            ST_SCAN: begin
                if (w_go) begin
                    if (!w_stat.full_len) begin
                        w_fin = 1'b1;
                    end else if (w_stat.match) begin
                        n_limit = w_lim_now;
                        if (!w_lim_now) begin
                            if (r_skip) begin
                                n_skip = 1'b0;
                            end else begin
                                w_em       = 1'b1;
                                w_res.kind = KIND_END_ELEM;
                                w_res.count = CNT_OUT_W'(CMP_W'(w_done_inc));
                                n_done     = w_done_inc;
                                n_cur      = '0;
                            end
                        end
                        if (w_stat.beyond_len) begin
                            w_ctl.shift = 1'b1;
                            n_drop      = w_len - 1'b1;
                        end else begin
                            w_ctl.clear = 1'b1;
                        end
                    end else begin
                        w_ctl.shift = 1'b1;
                        n_limit     = w_lim_now;
                        if (!w_lim_now && !r_skip) begin
                            w_em = 1'b1;
                            if (w_trunc) begin
                                w_res.kind  = KIND_END_ELEM;
                                w_res.count = CNT_OUT_W'(CMP_W'(w_done_inc));
                                n_done      = w_done_inc;
                                n_cur       = '0;
                                n_skip      = 1'b1;
                            end else begin
                                w_res.data = w_front;
                                n_cur      = w_cur_inc;
                            end
                        end
                    end
                end
            end
            ST_DROP: begin
                w_ctl.shift = 1'b1;
                n_drop      = r_drop - 1'b1;
            end
            ST_FLUSH: begin
                if (w_go && w_stat.front_valid) begin
                    w_ctl.shift = 1'b1;
                    n_limit     = w_lim_now;
                    if (!w_lim_now && !r_skip) begin
                        w_em = 1'b1;
                        if (w_trunc) begin
                            w_res.kind  = KIND_END_ELEM;
                            w_res.count = CNT_OUT_W'(CMP_W'(w_done_inc));
                            n_done      = w_done_inc;
                            n_cur       = '0;
                            n_skip      = 1'b1;
                        end else begin
                            w_res.data = w_front;
                            n_cur      = w_cur_inc;
                        end
                    end
                end
            end
            ST_CHAR: begin
                if (w_go) begin
                    n_limit = w_lim_now;
                    if (!w_lim_now) begin
                        w_em       = 1'b1;
                        w_res.data = r_byte;
                    end
                end
            end
            ST_CHAR_CLOSE: begin
                if (w_go) begin
                    w_em        = 1'b1;
                    w_res.kind  = KIND_END_ELEM;
                    w_res.count = CNT_OUT_W'(CMP_W'(w_done_inc));
                    n_done      = w_done_inc;
                    n_cur       = '0;
                end
            end
            ST_END_CLOSE: begin
                if (w_go && !r_limit && (CMP_W'(r_done) < CMP_W'(r_max_elems))
                        && (r_cur != '0)) begin
                    w_em        = 1'b1;
                    w_res.kind  = KIND_END_ELEM;
                    w_res.count = CNT_OUT_W'(CMP_W'(w_done_inc));
                    n_done      = w_done_inc;
                    n_cur       = '0;
                end
            end
            ST_END_MARK: begin
                if (w_go) begin
                    w_em        = 1'b1;
                    w_res.kind  = KIND_END_STR;
                    w_ctl.clear = 1'b1;
                    n_cur       = '0;
                    n_done      = '0;
                    n_skip      = 1'b0;
                    n_limit     = 1'b0;
                end
            end
            ST_FINISH: begin
                w_fin = w_go;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cur    <= '0;
            r_done   <= '0;
            r_skip   <= 1'b0;
            r_limit  <= 1'b0;
            r_drop   <= '0;
            r_zero   <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_done  <= n_done;
            r_skip  <= n_skip;
            r_limit <= n_limit;
            r_drop  <= n_drop;
            r_zero  <= n_zero;
            if (w_em) begin
                r_pend_v <= 1'b1;
            end else if (w_fin) begin
                r_pend_v <= 1'b0;
            end
            if ((w_em || w_fin) && r_pend_v) begin
                r_out_v <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // held word goes out once the next one, or the end of the run, is known
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        if (w_em) begin
            r_pend <= w_res;
        end
        if ((w_em || w_fin) && r_pend_v) begin
            r_out      <= r_pend;
            r_out_last <= w_fin;
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {r_out.count, r_out.data};
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out_last;

endmodule
